>>> rtl/tpsg_pkg.sv
package tpsg_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int PHASE_WIDTH   = 32;
    localparam int LANES         = 3;
    // x, y and z carry two guard bits above the q1.31 range
    localparam int DATA_W        = 34;
    localparam int SHIFT_W       = 5;

    localparam logic [31:0] OFFSET_120 = 32'h5555_5555;
    localparam logic [31:0] OFFSET_240 = 32'hAAAA_AAAB;
    localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_WIDTH)) - 32'd1);
    localparam logic signed [DATA_W-1:0] CORDIC_GAIN_Q31 = DATA_W'(1304065748);

    localparam logic [2:0] SECTOR_KEEP = 3'd7;

    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;

    typedef enum logic {
        OP_STEP   = 1'b0,
        OP_PRESET = 1'b1
    } t_op;

    typedef struct packed {
        logic       op;
        logic [2:0] sector;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sine_a;
        logic signed [31:0] cosine_a;
        logic signed [31:0] sine_b;
        logic signed [31:0] sine_c;
        logic [31:0]        phase_used;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     flip;
    } t_lane;

    typedef struct packed {
        logic                   valid;
        logic [31:0]            phase;
        t_lane [LANES-1:0]      lane;
    } t_stage;

    function automatic logic [31:0] quantize(input logic [31:0] a);
        return a & PHASE_MASK;
    endfunction

    function automatic logic [31:0] sector_angle(input logic [2:0] s);
        logic [31:0] r;
        case (s)
            3'd1:    r = 32'h2AAA_AAAB;
            3'd2:    r = 32'h5555_5555;
            3'd3:    r = 32'h8000_0000;
            3'd4:    r = 32'hAAAA_AAAB;
            3'd5:    r = 32'hD555_5555;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

    // atan(2^-i) in turns scaled by 2^32
    function automatic logic [31:0] atan_turn(input logic [SHIFT_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd536870912;
            5'd1:    r = 32'd316933406;
            5'd2:    r = 32'd167458907;
            5'd3:    r = 32'd85004756;
            5'd4:    r = 32'd42667331;
            5'd5:    r = 32'd21354465;
            5'd6:    r = 32'd10680862;
            5'd7:    r = 32'd5340245;
            5'd8:    r = 32'd2670163;
            5'd9:    r = 32'd1335087;
            5'd10:   r = 32'd667544;
            5'd11:   r = 32'd333772;
            5'd12:   r = 32'd166886;
            5'd13:   r = 32'd83443;
            5'd14:   r = 32'd41722;
            5'd15:   r = 32'd20861;
            5'd16:   r = 32'd10430;
            5'd17:   r = 32'd5215;
            5'd18:   r = 32'd2608;
            5'd19:   r = 32'd1304;
            5'd20:   r = 32'd652;
            5'd21:   r = 32'd326;
            5'd22:   r = 32'd163;
            5'd23:   r = 32'd81;
            5'd24:   r = 32'd41;
            5'd25:   r = 32'd20;
            5'd26:   r = 32'd10;
            5'd27:   r = 32'd5;
            5'd28:   r = 32'd3;
            5'd29:   r = 32'd1;
            5'd30:   r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // fold the angle into [-90, 90) degrees and load the start vector
    function automatic t_lane prep_lane(input logic [31:0] angle);
        logic [31:0] a;
        t_lane       r;
        a      = quantize(angle);
        r.flip = a[31] ^ a[30];
        if (r.flip) begin
            a = a ^ HALF_TURN;
        end
        r.z = signed'({{(DATA_W-32){a[31]}}, a});
        r.x = CORDIC_GAIN_Q31;
        r.y = '0;
        return r;
    endfunction

    function automatic logic signed [31:0] sat_q31(input logic signed [DATA_W-1:0] v);
        logic fits;
        fits = (&v[DATA_W-1:31]) || !(|v[DATA_W-1:31]);
        if (fits) begin
            return v[31:0];
        end
        return v[DATA_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    // undo the half-turn fold, then clamp to q1.31
    function automatic logic signed [31:0] finish(input logic signed [DATA_W-1:0] v,
                                                  input logic flip);
        logic signed [DATA_W-1:0] t;
        t = flip ? -v : v;
        return sat_q31(t);
    endfunction

endpackage

>>> rtl/tpsg_cell.sv
module tpsg_cell import tpsg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic [31:0]        i_atan,
    input  t_stage             i_stage,
    output t_stage             o_stage
);

    logic                     r_valid;
    t_stage                   r_stage;
    t_stage                   n_stage;
    logic signed [DATA_W-1:0] w_atan;

    assign w_atan = signed'({{(DATA_W-32){1'b0}}, i_atan});

    always_comb begin
        n_stage = i_stage;
        for (int l = 0; l < LANES; l++) begin
            // rotate toward z = 0, shifts are arithmetic (floor)
            if (!i_stage.lane[l].z[DATA_W-1]) begin
                n_stage.lane[l].x = i_stage.lane[l].x - (i_stage.lane[l].y >>> i_shift);
                n_stage.lane[l].y = i_stage.lane[l].y + (i_stage.lane[l].x >>> i_shift);
                n_stage.lane[l].z = i_stage.lane[l].z - w_atan;
            end else begin
                n_stage.lane[l].x = i_stage.lane[l].x + (i_stage.lane[l].y >>> i_shift);
                n_stage.lane[l].y = i_stage.lane[l].y - (i_stage.lane[l].x >>> i_shift);
                n_stage.lane[l].z = i_stage.lane[l].z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    always_comb begin
        o_stage       = r_stage;
        o_stage.valid = r_valid;
    end

endmodule

>>> rtl/tpsg_skid.sv
module tpsg_skid import tpsg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_ready
);

    logic      r_out_valid;
    logic      r_skid_full;
    t_out_item r_out;
    t_out_item r_skid;
    logic      w_take;
    logic      w_beat;

    assign w_take = r_out_valid && i_ready;
    // the chain only moves while the skid slot is free
    assign w_beat = i_valid && !r_skid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (w_take) begin
                r_skid_full <= 1'b0;
            end
        end else if (w_beat) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_full <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_beat) begin
            if (!r_out_valid || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_full  = r_skid_full;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid slot holds a beat while the output register is empty");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_valid && !i_ready && i_valid))
        else $error("skid slot filled without a stalled output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_full && i_ready) |=> (!r_skid_full && r_out_valid))
        else $error("skid slot did not drain when the output was taken");

endmodule

>>> rtl/three_phase_sine_generator.sv
// three-phase sine generator: dds phase accumulator feeding a cordic cell chain
//
// input channel (i_valid/o_ready, i_data): op step reports the sines at the
// current phase and then adds the phase increment; op preset loads the phase
// with sector*60 degrees (sectors 0 and 6 give zero, sector 7 keeps it) and
// reports the sines at the new phase.
// output channel (o_valid/i_ready, o_data): one beat per input beat, in order,
// with sine and cosine of phase a, sines at +120 and +240 degrees, and the
// phase that was used.
// apb port: register 0 at address 0 is the 32-bit phase increment.
// a beat passes one entry register, one cell per cordic stage (24) and one
// output register from accept to o_valid. one beat is accepted per cycle while
// o_ready is high; each cell is one shift-add stage for all three phases.
// a stalled output keeps its beat; the next finished beat parks in a skid slot
// and only then does the chain freeze and o_ready drop.
// reset clears the phase, the increment and all valid flags.
module three_phase_sine_generator import tpsg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_PHASE_INC = 1'b0;

    logic        r_front_valid;
    t_stage      r_front;
    logic [31:0] r_phase;
    logic [31:0] r_inc;
    logic        w_en;
    logic        w_accept;
    logic        w_full;
    logic [31:0] w_p;
    t_stage      w_stage [CORDIC_STAGES+1];
    t_stage      w_last;
    t_out_item   w_result;

    assign w_en     = !w_full;
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PHASE_INC) ? r_inc : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_PHASE_INC) begin
            r_inc <= pwdata;
        end
    end

    // phase seen by this beat
    always_comb begin
        w_p = r_phase;
        if (i_data.op == OP_PRESET && i_data.sector != SECTOR_KEEP) begin
            w_p = sector_angle(i_data.sector);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_front_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= (i_data.op == OP_STEP) ? w_p + r_inc : w_p;
            end
            if (w_en) begin
                r_front_valid <= w_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_front.valid        <= w_accept;
            r_front.phase        <= quantize(w_p);
            r_front.lane[LANE_A] <= prep_lane(w_p);
            r_front.lane[LANE_B] <= prep_lane(w_p + OFFSET_120);
            r_front.lane[LANE_C] <= prep_lane(w_p + OFFSET_240);
        end
    end

    always_comb begin
        w_stage[0]       = r_front;
        w_stage[0].valid = r_front_valid;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        tpsg_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (SHIFT_W'(g)),
            .i_atan  (atan_turn(SHIFT_W'(g))),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    assign w_last = w_stage[CORDIC_STAGES];

    always_comb begin
        w_result.sine_a     = finish(w_last.lane[LANE_A].y, w_last.lane[LANE_A].flip);
        w_result.cosine_a   = finish(w_last.lane[LANE_A].x, w_last.lane[LANE_A].flip);
        w_result.sine_b     = finish(w_last.lane[LANE_B].y, w_last.lane[LANE_B].flip);
        w_result.sine_c     = finish(w_last.lane[LANE_C].y, w_last.lane[LANE_C].flip);
        w_result.phase_used = w_last.phase;
    end

    tpsg_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_last.valid),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    a_step_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.op == OP_STEP) |=> (r_phase == $past(r_phase + r_inc)))
        else $error("phase did not advance by the increment after a step beat");

    a_preset_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_data.op == OP_PRESET && i_data.sector != SECTOR_KEEP)
        |=> (r_phase == $past(sector_angle(i_data.sector))))
        else $error("preset beat did not load the sector angle");

    a_front_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_front_valid) |-> $past(w_accept))
        else $error("entry register became valid without an accepted beat");

endmodule
